[hdl/pmd_pkg.sv]
// Package for the PS/2 mouse packet decoder: payload structs, register
// indexes, packet position codes and byte masks. No dependencies.
package pmd_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_BLOCK_ENABLED      = 2'd0;
  localparam logic [1:0] CFG_WHEEL_MODE         = 2'd1;
  localparam logic [1:0] CFG_EXTRA_BUTTONS_MODE = 2'd2;

  // Byte masks of the mouse protocol
  localparam logic [7:0] HDR_SYNC_MASK = 8'h08;
  localparam logic [7:0] BTN4_MASK     = 8'h10;
  localparam logic [7:0] BTN5_MASK     = 8'h20;
  localparam logic [7:0] NIBBLE_MASK   = 8'h0F;

  localparam int unsigned SUM_WIDTH = 16;

  // Position within a packet, one-hot
  typedef enum logic [3:0] {
    POS_HEAD  = 4'b0001,
    POS_X     = 4'b0010,
    POS_Y     = 4'b0100,
    POS_WHEEL = 4'b1000
  } pos_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       clear_motion;
  } in_t;

  typedef struct packed {
    logic                        left_button;
    logic                        right_button;
    logic                        middle_button;
    logic                        fourth_button;
    logic                        fifth_button;
    logic signed [SUM_WIDTH-1:0] sum_x;
    logic signed [SUM_WIDTH-1:0] sum_y;
    logic signed [SUM_WIDTH-1:0] sum_z;
    logic                        packet_done;
  } out_t;

endpackage

[hdl/ps2_mouse_packet_decoder.sv]
// Top level of the PS/2 mouse packet decoder (3-byte and 4-byte wheel packets).
// Depends on pmd_pkg.
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one mouse byte per
//   transaction plus a clear_motion flag that zeroes the x, y and wheel
//   accumulators before the byte is decoded.
//   Result channel (out_valid / out_stall / out_data) returns exactly one
//   result per input transaction: button state, the three accumulators
//   (16 bits, sign-extended or cut) and packet_done for a packet's last byte.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   block_enabled, wheel_mode and extra_buttons_mode; always ready. Writes
//   to an index past the list are taken and ignored.
// Timing:
//   Throughput is one byte per cycle unless the result stalls; decode and
//   saturating add sit between the state registers and the result register.
//   A stalled result holds and raises in_stall; it is the only buffer.
// Reset:
//   rst_n (synchronous, active low) returns to packet start, releases all
//   buttons, zeroes the accumulators, enables the block, clears both modes
//   and empties the result register.
module ps2_mouse_packet_decoder #(
  parameter int unsigned ACC_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  pmd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output pmd_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic          cfg_data
);

  // Sum width: two guard bits over the accumulator width
  localparam int unsigned SW = ACC_WIDTH + 2;
  localparam int unsigned OW = pmd_pkg::SUM_WIDTH;

  localparam logic signed [SW-1:0] ACC_HI =
    SW'((64'd1 << (ACC_WIDTH - 1)) - 64'd1);
  localparam logic signed [SW-1:0] ACC_LO = -ACC_HI - SW'(1);

  // Config registers
  logic enabled_r;
  logic wheel_mode_r;
  logic extra_mode_r;

  // Decoder state
  pmd_pkg::pos_t               pos_r, pos_nxt;
  logic [4:0]                  btn_r, btn_nxt;
  logic signed [ACC_WIDTH-1:0] acc_x_r, acc_x_nxt;
  logic signed [ACC_WIDTH-1:0] acc_y_r, acc_y_nxt;
  logic signed [ACC_WIDTH-1:0] acc_z_r, acc_z_nxt;
  logic                        done_nxt;

  // Result register
  logic          out_valid_r;
  pmd_pkg::out_t out_data_r, out_data_nxt;

  logic in_accept;

  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0] acc,
    input logic signed [SW-1:0]        delta
  );
    logic signed [SW-1:0] s;
    s = SW'(acc) + delta;
    if (s > ACC_HI) begin
      s = ACC_HI;
    end else if (s < ACC_LO) begin
      s = ACC_LO;
    end
    return s[ACC_WIDTH-1:0];
  endfunction

  // Accept whenever the result slot is free or is being taken this cycle
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= 1'b1;
      wheel_mode_r <= 1'b0;
      extra_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pmd_pkg::CFG_BLOCK_ENABLED:      enabled_r    <= cfg_data;
        pmd_pkg::CFG_WHEEL_MODE:         wheel_mode_r <= cfg_data;
        pmd_pkg::CFG_EXTRA_BUTTONS_MODE: extra_mode_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-byte decode
  always_comb begin
    logic [7:0]                  b;
    logic signed [SW-1:0]        dx8;
    logic signed [SW-1:0]        dz4;
    logic signed [ACC_WIDTH-1:0] ax, ay, az;
    b   = in_data.rx_byte;
    dx8 = {{(SW-8){b[7]}}, b};
    dz4 = {{(SW-4){b[3]}}, b[3:0] & pmd_pkg::NIBBLE_MASK[3:0]};

    // clear acts first, even when disabled
    ax = in_data.clear_motion ? '0 : acc_x_r;
    ay = in_data.clear_motion ? '0 : acc_y_r;
    az = in_data.clear_motion ? '0 : acc_z_r;

    pos_nxt   = pos_r;
    btn_nxt   = btn_r;
    acc_x_nxt = ax;
    acc_y_nxt = ay;
    acc_z_nxt = az;
    done_nxt  = 1'b0;

    if (!enabled_r) begin
      pos_nxt = pmd_pkg::POS_HEAD;
    end else begin
      unique case (pos_r)
        pmd_pkg::POS_HEAD: begin
          // header must carry the sync bit, else drop it
          if ((b & pmd_pkg::HDR_SYNC_MASK) != 8'h00) begin
            btn_nxt = {btn_r[4:3], b[2:0]};
            pos_nxt = pmd_pkg::POS_X;
          end
        end
        pmd_pkg::POS_X: begin
          acc_x_nxt = sat_add(ax, dx8);
          pos_nxt   = pmd_pkg::POS_Y;
        end
        pmd_pkg::POS_Y: begin
          acc_y_nxt = sat_add(ay, dx8);
          if (wheel_mode_r) begin
            pos_nxt = pmd_pkg::POS_WHEEL;
          end else begin
            pos_nxt  = pmd_pkg::POS_HEAD;
            done_nxt = 1'b1;
          end
        end
        pmd_pkg::POS_WHEEL: begin
          if (extra_mode_r) begin
            btn_nxt   = {(b & pmd_pkg::BTN5_MASK) != 8'h00,
                         (b & pmd_pkg::BTN4_MASK) != 8'h00,
                         btn_r[2:0]};
            acc_z_nxt = sat_add(az, dz4);
          end else begin
            // wheel byte is subtracted; -128 becomes +128
            acc_z_nxt = sat_add(az, -dx8);
          end
          pos_nxt  = pmd_pkg::POS_HEAD;
          done_nxt = 1'b1;
        end
        default: begin
          pos_nxt = pmd_pkg::POS_HEAD;
        end
      endcase
    end
  end

  // Result fields: accumulators sign-extended or truncated to 16 bits
  logic signed [OW-1:0] sum_x_w, sum_y_w, sum_z_w;
  generate
    if (ACC_WIDTH >= OW) begin : g_trunc
      assign sum_x_w = acc_x_nxt[OW-1:0];
      assign sum_y_w = acc_y_nxt[OW-1:0];
      assign sum_z_w = acc_z_nxt[OW-1:0];
    end else begin : g_sext
      assign sum_x_w = {{(OW-ACC_WIDTH){acc_x_nxt[ACC_WIDTH-1]}}, acc_x_nxt};
      assign sum_y_w = {{(OW-ACC_WIDTH){acc_y_nxt[ACC_WIDTH-1]}}, acc_y_nxt};
      assign sum_z_w = {{(OW-ACC_WIDTH){acc_z_nxt[ACC_WIDTH-1]}}, acc_z_nxt};
    end
  endgenerate

  always_comb begin
    out_data_nxt.left_button   = btn_nxt[0];
    out_data_nxt.right_button  = btn_nxt[1];
    out_data_nxt.middle_button = btn_nxt[2];
    out_data_nxt.fourth_button = btn_nxt[3];
    out_data_nxt.fifth_button  = btn_nxt[4];
    out_data_nxt.sum_x         = sum_x_w;
    out_data_nxt.sum_y         = sum_y_w;
    out_data_nxt.sum_z         = sum_z_w;
    out_data_nxt.packet_done   = done_nxt;
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= pmd_pkg::POS_HEAD;
      btn_r       <= '0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      acc_z_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        pos_r       <= pos_nxt;
        btn_r       <= btn_nxt;
        acc_x_r     <= acc_x_nxt;
        acc_y_r     <= acc_y_nxt;
        acc_z_r     <= acc_z_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Every accepted byte leaves a result waiting
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted byte produced no result");

  // A waiting packet_done result means the decoder is back at packet start
  a_done_at_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.packet_done) |-> (pos_r == pmd_pkg::POS_HEAD))
    else $error("packet_done without return to packet start");

  // A byte taken while disabled leaves the position at packet start
  a_disabled_head: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !enabled_r) |=> (pos_r == pmd_pkg::POS_HEAD))
    else $error("disabled block moved packet position");

endmodule

[verif/tb_ps2_mouse_packet_decoder.sv]
// Self-checking testbench for ps2_mouse_packet_decoder: directed and random mouse
// byte streams, each result checked against an in-bench packet decoder.
// Depends on pmd_pkg and the decoder RTL.
module tb_ps2_mouse_packet_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  // Index past the register list: the block takes the write and ignores it
  localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;
  // Cycles without any transaction before the run is declared hung
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SUM_MAX = (2 ** (int'(pmd_pkg::SUM_WIDTH) - 1)) - 1;
  localparam int SUM_MIN = -(2 ** (int'(pmd_pkg::SUM_WIDTH) - 1));

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  pmd_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  pmd_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [1:0]    cfg_index = pmd_pkg::CFG_BLOCK_ENABLED;
  logic          cfg_data  = 1'b0;

  // Decoder model: register copies and packet state
  logic                                 dec_enabled    = 1'b1;
  logic                                 dec_wheel_mode = 1'b0;
  logic                                 dec_extra_mode = 1'b0;
  pmd_pkg::pos_t                        dec_pos        = pmd_pkg::POS_HEAD;
  logic [4:0]                           dec_buttons    = '0;  // left..fifth
  logic signed [pmd_pkg::SUM_WIDTH-1:0] dec_sum_x      = '0;
  logic signed [pmd_pkg::SUM_WIDTH-1:0] dec_sum_y      = '0;
  logic signed [pmd_pkg::SUM_WIDTH-1:0] dec_sum_z      = '0;

  pmd_pkg::in_t  pending_bytes[$];     // bytes waiting to be sent
  pmd_pkg::out_t expected_reports[$];  // decoded state for bytes already taken

  int error_count   = 0;
  int idle_permille = 0;  // chance per cycle that a gap or stall burst starts
  int gap_left      = 0;
  int stall_left    = 0;
  int quiet_cycles  = 0;

  ps2_mouse_packet_decoder #(
    .ACC_WIDTH(pmd_pkg::SUM_WIDTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  function automatic logic signed [pmd_pkg::SUM_WIDTH-1:0] sat_add(
    logic signed [pmd_pkg::SUM_WIDTH-1:0] acc, int delta);
    int s;
    s = int'(acc) + delta;
    if (s > SUM_MAX) s = SUM_MAX;
    if (s < SUM_MIN) s = SUM_MIN;
    return s[pmd_pkg::SUM_WIDTH-1:0];
  endfunction

  // Advances the model by one byte and returns the state the block should report
  function automatic pmd_pkg::out_t decode_mouse_byte(pmd_pkg::in_t item);
    pmd_pkg::out_t rep;
    logic [3:0]    nib;
    rep = '0;
    // clear acts even while the block is disabled
    if (item.clear_motion) begin
      dec_sum_x = '0;
      dec_sum_y = '0;
      dec_sum_z = '0;
    end
    if (!dec_enabled) begin
      dec_pos = pmd_pkg::POS_HEAD;
    end else begin
      case (dec_pos)
        pmd_pkg::POS_HEAD: begin
          // header without the sync bit is dropped, position stays
          if ((item.rx_byte & pmd_pkg::HDR_SYNC_MASK) != '0) begin
            dec_buttons[2:0] = item.rx_byte[2:0];
            dec_pos = pmd_pkg::POS_X;
          end
        end
        pmd_pkg::POS_X: begin
          dec_sum_x = sat_add(dec_sum_x, int'($signed(item.rx_byte)));
          dec_pos = pmd_pkg::POS_Y;
        end
        pmd_pkg::POS_Y: begin
          dec_sum_y = sat_add(dec_sum_y, int'($signed(item.rx_byte)));
          // wheel mode is sampled here, not at the fourth byte
          if (dec_wheel_mode) begin
            dec_pos = pmd_pkg::POS_WHEEL;
          end else begin
            dec_pos = pmd_pkg::POS_HEAD;
            rep.packet_done = 1'b1;
          end
        end
        default: begin
          if (dec_extra_mode) begin
            nib = 4'(item.rx_byte & pmd_pkg::NIBBLE_MASK);
            dec_buttons[3] = (item.rx_byte & pmd_pkg::BTN4_MASK) != '0;
            dec_buttons[4] = (item.rx_byte & pmd_pkg::BTN5_MASK) != '0;
            dec_sum_z = sat_add(dec_sum_z, int'($signed(nib)));
          end else begin
            // wheel byte is subtracted; -128 becomes +128
            dec_sum_z = sat_add(dec_sum_z, -int'($signed(item.rx_byte)));
          end
          dec_pos = pmd_pkg::POS_HEAD;
          rep.packet_done = 1'b1;
        end
      endcase
    end
    rep.left_button   = dec_buttons[0];
    rep.right_button  = dec_buttons[1];
    rep.middle_button = dec_buttons[2];
    rep.fourth_button = dec_buttons[3];
    rep.fifth_button  = dec_buttons[4];
    rep.sum_x         = dec_sum_x;
    rep.sum_y         = dec_sum_y;
    rep.sum_z         = dec_sum_z;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    error_count++;
    $display("%0t ns mismatch: %s", $realtime, what);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver: takes the next pending byte unless a gap burst is running.
  // A stalled transaction holds valid and payload untouched.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // prediction happens at the edge that takes the byte
      if (in_valid && !in_stall) expected_reports.push_back(decode_mouse_byte(in_data));

      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (idle_permille > 0 && $urandom_range(0, 999) < idle_permille) begin
        gap_left = $urandom_range(1, 13) - 1;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        in_data  <= pending_bytes.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks every taken result against the oldest expectation,
  // and drives stall bursts independent of out_valid.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pmd_pkg::out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("result with no byte outstanding");
        end else begin
          want = expected_reports.pop_front();
          check_field("left_button",   out_data.left_button,   want.left_button);
          check_field("right_button",  out_data.right_button,  want.right_button);
          check_field("middle_button", out_data.middle_button, want.middle_button);
          check_field("fourth_button", out_data.fourth_button, want.fourth_button);
          check_field("fifth_button",  out_data.fifth_button,  want.fifth_button);
          check_field("sum_x",         out_data.sum_x,         want.sum_x);
          check_field("sum_y",         out_data.sum_y,         want.sum_y);
          check_field("sum_z",         out_data.sum_z,         want.sum_z);
          check_field("packet_done",   out_data.packet_done,   want.packet_done);
        end
      end

      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_permille > 0 && $urandom_range(0, 999) < idle_permille) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: any transaction on any channel resets the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_ps2_mouse_packet_decoder: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Nothing queued, nothing in flight, every result back; sampled mid-cycle
  // so the edge's updates have all landed
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_reports.size() != 0);
  endtask

  // Register write; the model copy changes at the same edge as the block's
  task automatic write_reg(logic [1:0] idx, logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      pmd_pkg::CFG_BLOCK_ENABLED:      dec_enabled    = val;
      pmd_pkg::CFG_WHEEL_MODE:         dec_wheel_mode = val;
      pmd_pkg::CFG_EXTRA_BUTTONS_MODE: dec_extra_mode = val;
      default: ;
    endcase
  endtask

  task automatic set_mode(logic en, logic wheel, logic extra);
    wait_idle();
    write_reg(pmd_pkg::CFG_BLOCK_ENABLED, en);
    write_reg(pmd_pkg::CFG_WHEEL_MODE, wheel);
    write_reg(pmd_pkg::CFG_EXTRA_BUTTONS_MODE, extra);
  endtask

  task automatic push_byte(logic [7:0] b, logic clr);
    pmd_pkg::in_t item;
    item.rx_byte      = b;
    item.clear_motion = clr;
    pending_bytes.push_back(item);
  endtask

  // One well-formed packet. drift > 0 pushes x and wheel up and y down at
  // near full scale, drift < 0 the other way, so the sums reach the rails.
  task automatic add_packet(logic with_wheel, int drift, logic clr_head);
    logic [7:0] dx, dy, dz;
    logic       mixed;
    mixed = (drift == 0);
    if (drift > 0) begin
      dx = 8'($urandom_range(124, 127));
      dy = 8'($urandom_range(128, 131));
      dz = 8'($urandom_range(128, 131));  // negative byte, subtracted
    end else if (drift < 0) begin
      dx = 8'($urandom_range(128, 131));
      dy = 8'($urandom_range(124, 127));
      dz = 8'($urandom_range(124, 127));
    end else begin
      dx = 8'($urandom);
      dy = 8'($urandom);
      dz = 8'($urandom);
    end
    push_byte(8'($urandom) | pmd_pkg::HDR_SYNC_MASK,
              clr_head || (mixed && $urandom_range(0, 31) == 0));
    push_byte(dx, mixed && $urandom_range(0, 31) == 0);
    push_byte(dy, mixed && $urandom_range(0, 31) == 0);
    if (with_wheel) push_byte(dz, mixed && $urandom_range(0, 31) == 0);
  endtask

  // Random phase: mostly whole packets, with loose bytes and cut packets mixed
  // in unless the phase drives the sums to saturation.
  task automatic run_random(logic en, logic wheel, logic extra, int n, int drift,
                            int permille);
    int added;
    set_mode(en, wheel, extra);
    idle_permille = permille;
    added = 0;
    while (added < n) begin
      if (drift == 0 && $urandom_range(0, 7) == 0) begin
        // loose bytes, any content
        repeat ($urandom_range(1, 3)) begin
          push_byte(8'($urandom), 1'($urandom_range(0, 1)));
          added++;
        end
      end else if (drift == 0 && $urandom_range(0, 7) == 0) begin
        // packet cut short after x; the next header lands on y
        push_byte(8'($urandom) | pmd_pkg::HDR_SYNC_MASK, 1'b0);
        push_byte(8'($urandom), 1'b0);
        added += 2;
      end else begin
        // first packet of a drift phase starts from zeroed sums
        add_packet(wheel, drift, drift != 0 && added == 0);
        added += wheel ? 4 : 3;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: plain 3-byte packets at the byte extremes
    idle_permille = 100;
    set_mode(1'b1, 1'b0, 1'b0);
    push_byte(8'h08, 1'b0);  // header, no buttons
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b1);  // clear, all three buttons
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h07, 1'b0);  // no sync bit: dropped
    push_byte(8'h0D, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h09, 1'b0);  // header left open, position at x

    // Disabled mid-packet: clear still acts, position falls back to header
    set_mode(1'b0, 1'b0, 1'b0);
    push_byte(8'h08, 1'b1);
    push_byte(8'hFF, 1'b0);
    wait_idle();
    write_reg(CFG_SPARE_INDEX, 1'b1);

    // Wheel packets; -128 on the wheel adds 128. Last packet stops at byte four.
    set_mode(1'b1, 1'b1, 1'b0);
    push_byte(8'h0A, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h08, 1'b0);
    push_byte(8'h05, 1'b0);
    push_byte(8'h05, 1'b0);

    // Modes change with a packet at byte four: it still decodes as byte four,
    // now with buttons four and five and a negative nibble
    set_mode(1'b1, 1'b0, 1'b1);
    push_byte(8'h38, 1'b0);
    push_byte(8'h0C, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);

    // Random phases across all mode settings, with and without idling
    run_random(1'b1, 1'b0, 1'b0, 100, 0, 150);
    run_random(1'b1, 1'b1, 1'b0, 100, 0, 60);
    run_random(1'b1, 1'b1, 1'b1, 100, 0, 250);
    run_random(1'b1, 1'b0, 1'b1, 100, 0, 0);
    // disabled phase also brings the position back to the header
    run_random(1'b0, 1'b1, 1'b1, 20, 0, 100);
    // saturation: x and wheel run into the upper rail, y into the lower
    run_random(1'b1, 1'b1, 1'b0, 1072, 1, 50);
    // closing stretch with no idling on either side
    run_random(1'b1, 1'b1, 1'b1, 150, 0, 0);

    wait_idle();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_ps2_mouse_packet_decoder: done, clean");
    end else begin
      $display("tb_ps2_mouse_packet_decoder: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/pmd_pkg.sv
hdl/ps2_mouse_packet_decoder.sv
verif/tb_ps2_mouse_packet_decoder.sv
